@@ hdl/irt_pkg.sv @@
// Package for the interval reservation table.
// Holds command and status codes, time width and the state machine type.
// No dependencies.
package irt_pkg;
   localparam int TIME_W = 16;
   localparam logic [1:0] CMD_RESERVE = 2'd0;
   localparam logic [1:0] CMD_QUERY   = 2'd1;
   localparam logic [1:0] CMD_CLEAR   = 2'd2;
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_EXEC = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;
endpackage

@@ hdl/irt_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module irt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ hdl/interval_reservation_table_top.sv @@
// Top level of the interval reservation table.
// Depends on irt_pkg and irt_ram.
//
// Usage. One item enters on the req_ channel (command, node, start_time,
// end_time) and one result item leaves on the rsp_ channel (status, is_free,
// next_free_time). An item is taken when valid is high and stall is low.
// Each node owns one row of the slot memory; a row holds all of the node's
// slots side by side (start, end and a valid bit for each), so one read
// fetches the whole set.
// Timing. An item is taken in the idle state, the row is read in the next
// cycle, compared and written back in the cycle after, and the result is
// presented in the output state. An item passes through each state of the
// controller in turn, and no new item is taken before it is back in idle.
// A clear item marks every row stale by advancing an epoch number kept with
// each row, so it passes through the states like any other item. After every
// 255th clear the rows are swept again, with req_stall high during the sweep.
// Reset. The state machine returns to idle; the epoch is set to all ones and
// wraps to zero at the end of a clearing pass over all NODE_COUNT rows, during
// which no item is taken, so that every stored epoch is defined.
// Stall. While the receiver stalls, the result holds and no new item is
// taken.
module interval_reservation_table_top #(
   parameter int NODE_COUNT     = 256,
   parameter int SLOTS_PER_NODE = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_command,
   input  logic [7:0]              req_node,
   input  logic [irt_pkg::TIME_W-1:0] req_start_time,
   input  logic [irt_pkg::TIME_W-1:0] req_end_time,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_status,
   output logic                    rsp_is_free,
   output logic [irt_pkg::TIME_W-1:0] rsp_next_free_time
);
   import irt_pkg::*;

   localparam int NW    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int EW    = 8;
   localparam int SLW   = 2 * TIME_W + 1;
   localparam int ROW_W = EW + SLOTS_PER_NODE * SLW;

   state_type         state_ff, state_in;
   logic [1:0]        cmd_ff, cmd_in;
   logic              inrange_ff, inrange_in;
   logic [NW-1:0]     node_ff, node_in;
   logic [TIME_W-1:0] s_ff, s_in, e_ff, e_in;
   logic [EW-1:0]     epoch_ff, epoch_in;
   logic              sweep_ff, sweep_in;
   logic [NW-1:0]     sweep_cnt_ff, sweep_cnt_in;
   logic [1:0]        st_ff, st_in;
   logic              fr_ff, fr_in;
   logic [TIME_W-1:0] nf_ff, nf_in;

   logic              wr_en;
   logic [NW-1:0]     wr_addr;
   logic [ROW_W-1:0]  wr_data, rd_data;

   irt_ram #(.WIDTH(ROW_W), .DEPTH(1 << NW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (node_ff),
      .rd_data (rd_data)
   );

   // Combinational merge and lookup over the row just read.
   logic                      row_live;
   logic [SLOTS_PER_NODE-1:0] v, absorb;
   logic [TIME_W-1:0]         ss [SLOTS_PER_NODE];
   logic [TIME_W-1:0]         se [SLOTS_PER_NODE];
   logic [TIME_W-1:0]         lo, hi, qnf;
   logic                      found, qfree;
   logic [ROW_W-1:0]          new_row;

   always_comb begin
      row_live = (rd_data[EW-1:0] == epoch_ff);
      lo = s_ff;
      hi = e_ff;
      found = 1'b0;
      qfree = 1'b1;
      qnf = s_ff;
      new_row = rd_data;
      for (int k = 0; k < SLOTS_PER_NODE; k++) begin
         v[k]  = row_live & rd_data[EW + k*SLW + 2*TIME_W];
         ss[k] = rd_data[EW + k*SLW +: TIME_W];
         se[k] = rd_data[EW + k*SLW + TIME_W +: TIME_W];
         absorb[k] = v[k] && (ss[k] <= e_ff) && (s_ff <= se[k]);
         if (absorb[k] && ss[k] < lo) lo = ss[k];
         if (absorb[k] && se[k] > hi) hi = se[k];
         if (v[k] && ss[k] <= s_ff && s_ff < se[k]) begin
            qfree = 1'b0;
            qnf = se[k];
         end
      end
      new_row[EW-1:0] = epoch_ff;
      for (int k = 0; k < SLOTS_PER_NODE; k++) begin
         new_row[EW + k*SLW + 2*TIME_W] = v[k] & ~absorb[k];
      end
      for (int k = 0; k < SLOTS_PER_NODE; k++) begin
         if (!found && (absorb[k] || !v[k])) begin
            found = 1'b1;
            new_row[EW + k*SLW +: SLW] = {1'b1, hi, lo};
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      inrange_in = inrange_ff;
      node_in = node_ff;
      s_in = s_ff;
      e_in = e_ff;
      epoch_in = epoch_ff;
      sweep_in = sweep_ff;
      sweep_cnt_in = sweep_cnt_ff;
      st_in = st_ff;
      fr_in = fr_ff;
      nf_in = nf_ff;
      wr_en = 1'b0;
      wr_addr = node_ff;
      wr_data = new_row;
      req_stall = !(state_ff == S_IDLE) || sweep_ff;
      case (state_ff)
         S_IDLE: begin
            if (sweep_ff) begin
               wr_en = 1'b1;
               wr_addr = sweep_cnt_ff;
               wr_data = '0;
               wr_data[EW-1:0] = epoch_ff + EW'(1);
               sweep_cnt_in = sweep_cnt_ff + NW'(1);
               if (sweep_cnt_ff == NW'(NODE_COUNT - 1)) sweep_in = 1'b0;
            end else if (req_valid) begin
               cmd_in = req_command;
               inrange_in = (32'(req_node) < NODE_COUNT);
               node_in = NW'(req_node);
               s_in = req_start_time;
               e_in = req_end_time;
               state_in = S_READ;
            end
         end
         S_READ: state_in = S_EXEC;
         S_EXEC: begin
            st_in = ST_OK;
            fr_in = 1'b0;
            nf_in = '0;
            case (cmd_ff)
               CMD_RESERVE: begin
                  if (s_ff >= e_ff) st_in = ST_EMPTY;
                  else if (!inrange_ff || !found) st_in = ST_FULL;
                  else wr_en = 1'b1;
               end
               CMD_QUERY: begin
                  fr_in = inrange_ff ? qfree : 1'b1;
                  nf_in = inrange_ff ? qnf : s_ff;
               end
               CMD_CLEAR: begin
                  // Rows holding another epoch read as empty. Before the
                  // counter wraps onto old rows, sweep again.
                  epoch_in = epoch_ff + EW'(1);
                  if (epoch_ff == '1 - EW'(1)) begin
                     sweep_in = 1'b1;
                     sweep_cnt_in = '0;
                  end
               end
               default: ;
            endcase
            state_in = S_OUT;
         end
         S_OUT: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         epoch_ff <= '1;
         sweep_ff <= 1'b1;
         sweep_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         epoch_ff <= (sweep_ff && sweep_cnt_ff == NW'(NODE_COUNT - 1))
                     ? epoch_ff + EW'(1) : epoch_in;
         sweep_ff <= sweep_in;
         sweep_cnt_ff <= sweep_cnt_in;
      end
      cmd_ff <= cmd_in;
      inrange_ff <= inrange_in;
      node_ff <= node_in;
      s_ff <= s_in;
      e_ff <= e_in;
      st_ff <= st_in;
      fr_ff <= fr_in;
      nf_ff <= nf_in;
   end

   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_status = st_ff;
   assign rsp_is_free = fr_ff;
   assign rsp_next_free_time = nf_ff;
endmodule

@@ test/interval_reservation_table_top_tb.sv @@
// Self-checking testbench for interval_reservation_table_top.
// Depends on irt_pkg and the block's RTL; it predicts every result item from its own
// copy of the slot table and compares each result field by field.
module interval_reservation_table_top_tb;
   import irt_pkg::*;

   localparam int NODES = 256;
   localparam int SLOTS = 8;

   // One request item as it is driven onto the req_ ports.
   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  node;
      logic [15:0] start_time;
      logic [15:0] end_time;
   } request_type;

   // One result item as it is expected on the rsp_ ports.
   typedef struct packed {
      logic [1:0]  status;
      logic        is_free;
      logic [15:0] next_free_time;
   } outcome_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_command;
   logic [7:0]  req_node;
   logic [15:0] req_start_time;
   logic [15:0] req_end_time;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic        rsp_is_free;
   logic [15:0] rsp_next_free_time;

   interval_reservation_table_top #(.NODE_COUNT(NODES), .SLOTS_PER_NODE(SLOTS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_command(req_command), .req_node(req_node),
      .req_start_time(req_start_time), .req_end_time(req_end_time),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_is_free(rsp_is_free),
      .rsp_next_free_time(rsp_next_free_time)
   );

   // The testbench's own copy of the interval table.
   logic [15:0] table_lo [NODES*SLOTS];
   logic [15:0] table_hi [NODES*SLOTS];
   logic        table_used [NODES*SLOTS];

   request_type pending_items[$];
   outcome_type expected_outcomes[$];
   int       mismatch_count;
   int       results_seen;
   int       items_sent;
   int       sender_idle_pct;
   int       receiver_stall_pct;

   // Clock with a period of 12 time units.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Works out the result of one accepted item and updates the table copy, so that
   // the expectation always reflects every item accepted before it.
   function automatic outcome_type predict_outcome(request_type item);
      outcome_type o;
      int         base;
      int         target;
      logic [15:0] lo;
      logic [15:0] hi;
      bit         absorb [SLOTS];
      o = '0;
      case (item.command)
         CMD_RESERVE: begin
            if (item.start_time >= item.end_time) begin
               o.status = ST_EMPTY;
            end else begin
               base = item.node * SLOTS;
               lo = item.start_time;
               hi = item.end_time;
               target = -1;
               for (int k = 0; k < SLOTS; k++) begin
                  // Touching intervals count as overlapping, hence the closed compares.
                  absorb[k] = table_used[base+k] && table_lo[base+k] <= item.end_time
                     && item.start_time <= table_hi[base+k];
                  if (absorb[k]) begin
                     if (table_lo[base+k] < lo) lo = table_lo[base+k];
                     if (table_hi[base+k] > hi) hi = table_hi[base+k];
                  end
                  if (target < 0 && (absorb[k] || !table_used[base+k])) target = k;
               end
               if (target < 0) begin
                  o.status = ST_FULL;
               end else begin
                  for (int k = 0; k < SLOTS; k++) begin
                     if (absorb[k]) table_used[base+k] = 1'b0;
                  end
                  table_lo[base+target] = lo;
                  table_hi[base+target] = hi;
                  table_used[base+target] = 1'b1;
                  o.status = ST_OK;
               end
            end
         end
         CMD_QUERY: begin
            base = item.node * SLOTS;
            o.is_free = 1'b1;
            o.next_free_time = item.start_time;
            for (int k = 0; k < SLOTS; k++) begin
               if (table_used[base+k] && table_lo[base+k] <= item.start_time
                   && item.start_time < table_hi[base+k]) begin
                  o.is_free = 1'b0;
                  o.next_free_time = table_hi[base+k];
               end
            end
         end
         CMD_CLEAR: begin
            for (int i = 0; i < NODES*SLOTS; i++) table_used[i] = 1'b0;
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   task automatic add_item(logic [1:0] c, logic [7:0] n, logic [15:0] s, logic [15:0] e);
      request_type r;
      r.command = c;
      r.node = n;
      r.start_time = s;
      r.end_time = e;
      pending_items.push_back(r);
   endtask

   // Random time drawn mostly from a narrow window, so that intervals collide,
   // with occasional draws from the whole range.
   function automatic logic [15:0] pick_time();
      if ($urandom_range(0, 9) == 0) return 16'($urandom_range(0, 65535));
      return 16'($urandom_range(0, 300));
   endfunction

   // Random node, mostly from a few hot nodes so that slots fill up.
   function automatic logic [7:0] pick_node();
      if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, 3));
   endfunction

   // Driver: presents the next pending item, and holds it while stalled.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         // The current item (if any) has been taken at this edge.
         if (req_valid) items_sent <= items_sent + 1;
         if (pending_items.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            request_type r;
            r = pending_items.pop_front();
            req_valid <= 1'b1;
            req_command <= r.command;
            req_node <= r.node;
            req_start_time <= r.start_time;
            req_end_time <= r.end_time;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Acceptance and prediction happen at the same edge, before the result can appear.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         expected_outcomes.push_back(predict_outcome({req_command, req_node,
                                                      req_start_time, req_end_time}));
      end
   end

   // Monitor: checks each accepted result item and picks the next stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            outcome_type want;
            if (expected_outcomes.size() == 0) begin
               $display("unexpected result item at %0t", $realtime);
               mismatch_count++;
            end else begin
               want = expected_outcomes.pop_front();
               results_seen++;
               if (rsp_status !== want.status)
                  report_mismatch("status", int'(rsp_status), int'(want.status));
               if (rsp_is_free !== want.is_free)
                  report_mismatch("is_free", int'(rsp_is_free), int'(want.is_free));
               if (rsp_next_free_time !== want.next_free_time)
                  report_mismatch("next_free_time", int'(rsp_next_free_time),
                                  int'(want.next_free_time));
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   // Main sequence: reset, directed items, then random items over four idling phases.
   initial begin
      req_valid = 1'b0;
      req_command = CMD_QUERY;
      req_node = '0;
      req_start_time = '0;
      req_end_time = '0;
      rsp_stall = 1'b0;
      reset = 1'b1;
      mismatch_count = 0;
      results_seen = 0;
      items_sent = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      for (int i = 0; i < NODES*SLOTS; i++) begin
         table_used[i] = 1'b0;
         table_lo[i] = '0;
         table_hi[i] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty and reversed ranges, full range, touching and overlapping
      // merges, a full node, the top time value, the unused command and a clear.
      add_item(CMD_RESERVE, 8'd0, 16'd10, 16'd10);
      add_item(CMD_RESERVE, 8'd0, 16'd20, 16'd5);
      add_item(CMD_RESERVE, 8'd255, 16'd0, 16'hFFFF);
      add_item(CMD_QUERY, 8'd255, 16'hFFFE, 16'hFFFF);
      add_item(CMD_QUERY, 8'd255, 16'hFFFF, 16'd0);
      add_item(CMD_RESERVE, 8'd1, 16'd10, 16'd20);
      add_item(CMD_RESERVE, 8'd1, 16'd20, 16'd30);
      add_item(CMD_RESERVE, 8'd1, 16'd5, 16'd12);
      add_item(CMD_QUERY, 8'd1, 16'd29, 16'd0);
      add_item(CMD_QUERY, 8'd1, 16'd30, 16'd0);
      for (int k = 0; k < SLOTS + 1; k++) add_item(CMD_RESERVE, 8'd2, 16'(k*10), 16'(k*10+5));
      add_item(CMD_RESERVE, 8'd2, 16'd4, 16'd71);
      add_item(CMD_QUERY, 8'd2, 16'd40, 16'd0);
      add_item(2'd3, 8'hAA, 16'h5555, 16'hAAAA);
      add_item(CMD_CLEAR, 8'd0, 16'd0, 16'd0);
      add_item(CMD_QUERY, 8'd1, 16'd15, 16'd0);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 56; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 56; end
            default: begin sender_idle_pct = 27; receiver_stall_pct = 27; end
         endcase
         for (int i = 0; i < 100; i++) begin
            int pick;
            logic [15:0] s;
            pick = $urandom_range(0, 99);
            s = pick_time();
            if (pick < 50)
               add_item(CMD_RESERVE, pick_node(), s, s + 16'($urandom_range(0, 40)) - 16'd2);
            else if (pick < 92)
               add_item(CMD_QUERY, pick_node(), s, 16'($urandom));
            else if (pick < 95)
               add_item(CMD_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom));
            else
               add_item(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom),
                        16'($urandom));
         end
         while (pending_items.size() > 0 || req_valid || expected_outcomes.size() > 0)
            @(posedge clock);
      end
      repeat (20) @(posedge clock);

      $display("Drove %0d items and checked %0d result items over four idling phases,",
               items_sent, results_seen);
      $display("with merges, full nodes, empty ranges, clears and queries at both ends.");
      if (mismatch_count == 0 && expected_outcomes.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Guard against a hung handshake: well beyond the slowest correct run.
   initial begin
      #3000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

@@ interval_reservation_table_top.f @@
hdl/irt_pkg.sv
hdl/irt_ram.sv
hdl/interval_reservation_table_top.sv
test/interval_reservation_table_top_tb.sv
